// ----- hdl/cmtxs_pkg.sv -----
// Shared types and constants of the CAN message transmit scheduler.
// Used by the entry memory, the entry unit and the top level; no dependencies.
`timescale 1ns / 1ps

package cmtxs_pkg;

    localparam int DEFAULT_MAX_ENTRIES  = 32;
    localparam int DEFAULT_NUM_CHANNELS = 4;

    localparam int ID_W    = 29;
    localparam int CD_W    = 16;
    localparam int ENT_W   = 5;
    localparam int PHASE_W = 3;
    localparam int MAX_CH  = 4;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int CNT_CFG_W   = 6;
    localparam int ACT_CFG_W   = 4;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_START    = 2'd1,
        OP_TICK     = 2'd2,
        OP_PASS     = 2'd3
    } t_opcode;

    localparam logic [1:0] KIND_CYCLIC   = 2'd0;
    localparam logic [1:0] KIND_ON_START = 2'd1;

    typedef struct packed {
        logic       ext;
        logic [1:0] ch;
        logic       en;
        logic [1:0] kind;
    } t_attr;

    typedef struct packed {
        t_attr            attr;
        logic [ID_W-1:0]  id;
        logic [CD_W-1:0]  period;
        logic [CD_W-1:0]  countdown;
    } t_entry;

    typedef struct packed {
        logic            wr_en;
        logic [CD_W-1:0] countdown;
        logic            set_pend;
        logic            take;
    } t_unit_res;

endpackage

// ----- hdl/cmtxs_entry_ram.sv -----
// Message table memory: one write port, one registered read port.
// Depends on cmtxs_pkg for the entry layout.
`timescale 1ns / 1ps

module cmtxs_entry_ram #(
    parameter int DEPTH = cmtxs_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  cmtxs_pkg::t_entry                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output cmtxs_pkg::t_entry                      o_rdata
);

    cmtxs_pkg::t_entry r_mem [DEPTH];
    cmtxs_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/cmtxs_entry_unit.sv -----
// Shared per-entry unit: tick countdown, on-start trigger and channel take decision.
// Depends on cmtxs_pkg for opcodes, entry layout and result struct.
`timescale 1ns / 1ps

module cmtxs_entry_unit (
    input  cmtxs_pkg::t_opcode             i_op,
    input  cmtxs_pkg::t_entry              i_entry,
    input  logic                           i_pend,
    input  logic [cmtxs_pkg::MAX_CH-1:0]   i_cap,
    output cmtxs_pkg::t_unit_res           o_res
);

    logic [cmtxs_pkg::CD_W-1:0] dec;

    always_comb begin
        dec             = i_entry.countdown - cmtxs_pkg::CD_W'(1);
        o_res           = '0;
        o_res.countdown = i_entry.countdown;
        unique case (i_op)
            cmtxs_pkg::OP_REGISTER: begin
                o_res.wr_en = 1'b0;
            end
            cmtxs_pkg::OP_START: begin
                o_res.set_pend = i_entry.attr.en &&
                                 (i_entry.attr.kind == cmtxs_pkg::KIND_ON_START);
            end
            cmtxs_pkg::OP_TICK: begin
                if (i_entry.attr.en && (i_entry.attr.kind == cmtxs_pkg::KIND_CYCLIC)) begin
                    o_res.wr_en = 1'b1;
                    if (dec == '0) begin
                        o_res.countdown = i_entry.period;
                        o_res.set_pend  = 1'b1;
                    end else begin
                        o_res.countdown = dec;
                    end
                end
            end
            cmtxs_pkg::OP_PASS: begin
                o_res.take = i_pend && i_cap[i_entry.attr.ch];
            end
            default: begin
                o_res.wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/can_message_tx_scheduler_core.sv -----
// CAN message transmit scheduler top level: APB registers, sequencer, channel phases.
// Depends on cmtxs_pkg, cmtxs_entry_ram and cmtxs_entry_unit.
//
// Each input transfer carries an opcode in tuser: register an entry, trigger on-start
// entries, apply a 1 ms tick, or run one pass over the active channels. A register
// request goes straight to the acknowledgement state, which holds tready low until
// the result register takes its acknowledgement. Trigger, tick and pass walk the table
// once through the single read port of the entry memory and the shared entry unit,
// one entry per cycle, over the first min(message_count, MAX_ENTRIES) entries. A pass
// with an active channel then steps the channels from channel 0 up to the highest
// active one, one per cycle unless the result side stalls an active channel, with one
// result per active channel; trigger, tick and a pass with no active channel finish
// with one acknowledgement. tready is low while an item is in work, and stalls on the
// result side keep it low longer. No clearing pass.
`timescale 1ns / 1ps

module can_message_tx_scheduler_core #(
    parameter int MAX_ENTRIES  = cmtxs_pkg::DEFAULT_MAX_ENTRIES,
    parameter int NUM_CHANNELS = cmtxs_pkg::DEFAULT_NUM_CHANNELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmtxs_pkg::APB_AW-1:0]        paddr,
    input  logic [cmtxs_pkg::APB_DW-1:0]        pwdata,
    output logic [cmtxs_pkg::APB_DW-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index, message_id, extended_id, target_channel, enable, message_kind,
    // interval_ms, busy_mask, zero fill
    input  logic [cmtxs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // opcode
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // channel_index, channel_phase, send_now, sent_entry, sent_id, sent_extended,
    // zero fill
    output logic [cmtxs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int NCH = (NUM_CHANNELS < cmtxs_pkg::MAX_CH) ? NUM_CHANNELS : cmtxs_pkg::MAX_CH;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PAD_W = cmtxs_pkg::OUT_TDATA_W - 2 - cmtxs_pkg::PHASE_W - 1
                           - cmtxs_pkg::ENT_W - cmtxs_pkg::ID_W - 1;

    localparam logic REG_MSG_COUNT = 1'b0;
    localparam logic REG_ACTIVE    = 1'b1;

    localparam logic [cmtxs_pkg::PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [cmtxs_pkg::PHASE_W-1:0] PH_SEND     = 3'd1;
    localparam logic [cmtxs_pkg::PHASE_W-1:0] PH_WAIT     = 3'd2;
    localparam logic [cmtxs_pkg::PHASE_W-1:0] PH_COMPLETE = 3'd3;
    localparam logic [cmtxs_pkg::PHASE_W-1:0] PH_DONE     = 3'd4;

    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_SCAN = 4'b0010,
        SQ_CHAN = 4'b0100,
        SQ_ACK  = 4'b1000
    } t_seq;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SEND     = 5'b00010,
        ST_WAIT     = 5'b00100,
        ST_COMPLETE = 5'b01000,
        ST_DONE     = 5'b10000
    } t_phase;

    function automatic logic [cmtxs_pkg::PHASE_W-1:0] phase_code(input t_phase p);
        logic [cmtxs_pkg::PHASE_W-1:0] c;
        unique case (p)
            ST_IDLE:     c = PH_IDLE;
            ST_SEND:     c = PH_SEND;
            ST_WAIT:     c = PH_WAIT;
            ST_COMPLETE: c = PH_COMPLETE;
            ST_DONE:     c = PH_DONE;
            default:     c = PH_IDLE;
        endcase
        return c;
    endfunction

    // configuration
    logic [cmtxs_pkg::CNT_CFG_W-1:0] r_msg_count;
    logic [cmtxs_pkg::ACT_CFG_W-1:0] r_active;
    logic                            cfg_wr;
    logic [CW-1:0]                   used_n;

    // input fields
    logic [4:0]                  in_entry_index;
    logic [cmtxs_pkg::ID_W-1:0]  in_message_id;
    logic                        in_extended_id;
    logic [1:0]                  in_target_channel;
    logic                        in_enable;
    logic [1:0]                  in_message_kind;
    logic [cmtxs_pkg::CD_W-1:0]  in_interval_ms;
    logic [3:0]                  in_busy_mask;
    cmtxs_pkg::t_opcode          in_op;
    logic                        accept;
    logic                        reg_hit;

    // sequencer
    t_seq                 r_state;
    t_seq                 n_state;
    cmtxs_pkg::t_opcode   r_op;
    logic [3:0]           r_busy;
    logic [CW-1:0]        r_idx;
    logic                 r_p_vld;
    logic [IW-1:0]        r_p_idx;
    logic                 issue;
    logic                 scan_done;

    // table
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    cmtxs_pkg::t_entry     mem_wdata;
    cmtxs_pkg::t_entry     p_entry;
    logic                  r_pend [MAX_ENTRIES];
    logic                  p_pend;
    cmtxs_pkg::t_unit_res  u_res;
    logic [cmtxs_pkg::MAX_CH-1:0] cap;

    // channels
    t_phase                      r_phase        [NCH];
    logic [cmtxs_pkg::ENT_W-1:0] r_held_entry   [NCH];
    logic [cmtxs_pkg::ID_W-1:0]  r_held_id      [NCH];
    logic                        r_held_ext     [NCH];
    logic [cmtxs_pkg::MAX_CH-1:0] r_found;
    logic [CHW-1:0]              r_ch;
    logic                        ch_act;
    logic                        higher;
    logic                        snd;
    t_phase                      nxt;

    // result register
    logic                               r_out_vld;
    logic [cmtxs_pkg::OUT_TDATA_W-1:0]  r_out_data;
    logic                               r_out_last;
    logic                               out_free;
    logic                               out_load;
    logic [cmtxs_pkg::OUT_TDATA_W-1:0]  out_data;
    logic                               out_last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_MSG_COUNT: prdata = {{(cmtxs_pkg::APB_DW - cmtxs_pkg::CNT_CFG_W){1'b0}},
                                     r_msg_count};
            REG_ACTIVE:    prdata = {{(cmtxs_pkg::APB_DW - cmtxs_pkg::ACT_CFG_W){1'b0}},
                                     r_active};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        if (32'(r_msg_count) >= MAX_ENTRIES) begin
            used_n = CW'(MAX_ENTRIES);
        end else begin
            used_n = CW'(r_msg_count);
        end
    end

    // input unpack
    assign in_entry_index    = s_axis_tdata[4:0];
    assign in_message_id     = s_axis_tdata[33:5];
    assign in_extended_id    = s_axis_tdata[34];
    assign in_target_channel = s_axis_tdata[36:35];
    assign in_enable         = s_axis_tdata[37];
    assign in_message_kind   = s_axis_tdata[39:38];
    assign in_interval_ms    = s_axis_tdata[55:40];
    assign in_busy_mask      = s_axis_tdata[59:56];
    assign in_op             = cmtxs_pkg::t_opcode'(s_axis_tuser);

    assign s_axis_tready = (r_state == SQ_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign reg_hit       = (32'(in_entry_index) < 32'(used_n));

    // table walk
    assign issue     = (r_state == SQ_SCAN) && (r_idx < used_n);
    assign scan_done = (r_state == SQ_SCAN) && !issue && !r_p_vld;
    assign p_pend    = r_pend[r_p_idx];

    always_comb begin
        cap = '0;
        for (int k = 0; k < NCH; k++) begin
            cap[k] = r_active[k] && (r_phase[CHW'(k)] == ST_IDLE) && !r_found[k];
        end
    end

    cmtxs_entry_unit u_unit (
        .i_op    (r_op),
        .i_entry (p_entry),
        .i_pend  (p_pend),
        .i_cap   (cap),
        .o_res   (u_res)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = IW'(in_entry_index);
        mem_wdata = p_entry;
        if (r_p_vld) begin
            mem_we              = u_res.wr_en;
            mem_waddr           = r_p_idx;
            mem_wdata.countdown = u_res.countdown;
        end else begin
            mem_we                = accept && (in_op == cmtxs_pkg::OP_REGISTER) && reg_hit;
            mem_wdata.attr.ext    = in_extended_id;
            mem_wdata.attr.ch     = in_target_channel;
            mem_wdata.attr.en     = in_enable;
            mem_wdata.attr.kind   = in_message_kind;
            mem_wdata.id          = in_message_id;
            mem_wdata.period      = in_interval_ms;
            mem_wdata.countdown   = in_interval_ms;
        end
    end

    cmtxs_entry_ram #(
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (p_entry)
    );

    // channel step
    assign out_free = !r_out_vld || m_axis_tready;
    assign ch_act   = r_active[2'(r_ch)];

    always_comb begin
        higher = 1'b0;
        for (int k = 0; k < NCH; k++) begin
            if ((k > int'(r_ch)) && r_active[k]) begin
                higher = 1'b1;
            end
        end
    end

    always_comb begin
        snd = 1'b0;
        unique case (r_phase[r_ch])
            ST_IDLE:     nxt = r_found[2'(r_ch)] ? ST_SEND : ST_IDLE;
            ST_SEND: begin
                nxt = ST_WAIT;
                snd = 1'b1;
            end
            ST_WAIT:     nxt = r_busy[2'(r_ch)] ? ST_WAIT : ST_COMPLETE;
            ST_COMPLETE: nxt = ST_DONE;
            ST_DONE:     nxt = ST_IDLE;
            default:     nxt = ST_IDLE;
        endcase
    end

    always_comb begin
        out_load = 1'b0;
        out_data = '0;
        out_last = 1'b1;
        if (r_state == SQ_ACK) begin
            out_load = out_free;
        end else if (r_state == SQ_CHAN) begin
            out_load = ch_act && out_free;
            out_last = !higher;
            if (snd) begin
                out_data = {{PAD_W{1'b0}}, r_held_ext[r_ch], r_held_id[r_ch],
                            r_held_entry[r_ch], 1'b1, phase_code(nxt), 2'(r_ch)};
            end else begin
                out_data = {{PAD_W{1'b0}}, 1'b0, {cmtxs_pkg::ID_W{1'b0}},
                            {cmtxs_pkg::ENT_W{1'b0}}, 1'b0, phase_code(nxt), 2'(r_ch)};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_IDLE: begin
                if (accept) begin
                    n_state = (in_op == cmtxs_pkg::OP_REGISTER) ? SQ_ACK : SQ_SCAN;
                end
            end
            SQ_SCAN: begin
                if (scan_done) begin
                    n_state = ((r_op == cmtxs_pkg::OP_PASS) && (|r_active[NCH-1:0]))
                              ? SQ_CHAN : SQ_ACK;
                end
            end
            SQ_CHAN: begin
                if (ch_act && out_free && !higher) begin
                    n_state = SQ_IDLE;
                end
            end
            SQ_ACK: begin
                if (out_free) begin
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_count <= '0;
            r_active    <= '0;
            r_state     <= SQ_IDLE;
            r_idx       <= '0;
            r_p_vld     <= 1'b0;
            r_found     <= '0;
            r_ch        <= '0;
            r_out_vld   <= 1'b0;
            for (int k = 0; k < NCH; k++) begin
                r_phase[k] <= ST_IDLE;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_MSG_COUNT: r_msg_count <= pwdata[cmtxs_pkg::CNT_CFG_W-1:0];
                    REG_ACTIVE:    r_active    <= pwdata[cmtxs_pkg::ACT_CFG_W-1:0];
                    default:       r_active    <= r_active;
                endcase
            end
            r_state <= n_state;
            r_p_vld <= issue;
            if (accept) begin
                r_idx   <= '0;
                r_found <= '0;
            end else begin
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_p_vld && u_res.take) begin
                    r_found[p_entry.attr.ch] <= 1'b1;
                end
            end
            if (scan_done) begin
                r_ch <= '0;
            end else if ((r_state == SQ_CHAN) && (!ch_act || out_free)) begin
                r_ch <= r_ch + CHW'(1);
            end
            if ((r_state == SQ_CHAN) && ch_act && out_free) begin
                r_phase[r_ch] <= nxt;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ENTRIES; k++) begin
                r_pend[k] <= 1'b0;
            end
        end else begin
            if (accept && (in_op == cmtxs_pkg::OP_REGISTER) && reg_hit) begin
                r_pend[IW'(in_entry_index)] <= 1'b0;
            end
            if (r_p_vld && u_res.set_pend) begin
                r_pend[r_p_idx] <= 1'b1;
            end
            if (r_p_vld && u_res.take) begin
                r_pend[r_p_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= in_op;
            r_busy <= in_busy_mask;
        end
        r_p_idx <= r_idx[IW-1:0];
        if (r_p_vld && u_res.take) begin
            r_held_entry[CHW'(p_entry.attr.ch)] <= cmtxs_pkg::ENT_W'(r_p_idx);
            r_held_id[CHW'(p_entry.attr.ch)]    <= p_entry.id;
            r_held_ext[CHW'(p_entry.attr.ch)]   <= p_entry.attr.ext;
        end
        if (out_load) begin
            r_out_data <= out_data;
            r_out_last <= out_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    a_take_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_vld && u_res.take) |-> r_active[p_entry.attr.ch])
        else $error("entry taken by an inactive channel");

    a_nonlast_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (r_op == cmtxs_pkg::OP_PASS))
        else $error("non-final result outside a channel pass");

    a_send_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[4:2] == PH_WAIT))
        else $error("send result not followed by wait phase");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while item in work");
`endif

endmodule

// ----- tb/sv/tb_can_message_tx_scheduler_core.sv -----
// Self-checking testbench for can_message_tx_scheduler_core: stream stimulus, APB setup,
// a cycle-free predictor of the entry table and the channel phases, and result checking.
// Depends on cmtxs_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module tb_can_message_tx_scheduler_core;
    import cmtxs_pkg::*;

    localparam int ENTRIES         = DEFAULT_MAX_ENTRIES;
    localparam int CHANNELS        = DEFAULT_NUM_CHANNELS;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int TAIL_CYCLES     = 64;
    localparam int MAX_REPORTED    = 10;
    localparam int DIR_ROWS        = 23;
    localparam int DIR_RESET_ROWS  = 4;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 22;

    localparam logic [APB_AW-1:0] ADDR_MESSAGE_COUNT   = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_ACTIVE_CHANNELS = 3'd4;

    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum bit [2:0] {
        PH_IDLE     = 3'd0,
        PH_SEND     = 3'd1,
        PH_WAIT     = 3'd2,
        PH_COMPLETE = 3'd3,
        PH_DONE     = 3'd4
    } ch_phase_t;

    typedef struct packed {
        t_opcode          op;
        logic [ENT_W-1:0] idx;
        logic [ID_W-1:0]  id;
        logic             ext;
        logic [1:0]       ch;
        logic             en;
        logic [1:0]       kind;
        logic [CD_W-1:0]  interval;
        logic [3:0]       busy;
    } sched_cmd_t;

    // Same bit order as {tlast, tdata[40:0]}.
    typedef struct packed {
        logic               last;
        logic               ext;
        logic [ID_W-1:0]    id;
        logic [ENT_W-1:0]   entry;
        logic               send;
        logic [PHASE_W-1:0] phase;
        logic [1:0]         ch;
    } ch_report_t;

    typedef struct {
        sched_cmd_t cmd;
        bit         typed;
        ch_report_t want;
    } dir_row_t;

    localparam ch_report_t ACK = {1'b1, 41'd0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    bit [ID_W-1:0]        tbl_id        [ENTRIES];
    t_attr                tbl_attr      [ENTRIES];
    bit [CD_W-1:0]        tbl_period    [ENTRIES];
    bit [CD_W-1:0]        tbl_countdown [ENTRIES];
    bit                   tbl_pending   [ENTRIES];
    bit                   tbl_written   [ENTRIES];
    ch_phase_t            ch_phase      [CHANNELS];
    bit [ENT_W-1:0]       held_entry    [CHANNELS];
    bit [ID_W-1:0]        held_id       [CHANNELS];
    bit                   held_ext      [CHANNELS];
    bit [CNT_CFG_W-1:0]   cfg_count;
    bit [ACT_CFG_W-1:0]   cfg_active;

    ch_report_t step_reports [MAX_CH];
    int         step_count;
    ch_report_t reports_due [$];

    int fault_count;
    int transfer_count;
    int burst_left;
    int rx_mode;
    int rx_span;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{'{OP_REGISTER, 5'd0, 29'h1FFFFFFF, 1'b1, 2'd3, 1'b1, KIND_CYCLIC, 16'd5, 4'd0},
          1'b1, ACK},
        '{'{OP_START, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'd0}, 1'b1, ACK},
        '{'{OP_TICK, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'd0}, 1'b1, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'hF}, 1'b1, ACK},
        '{'{OP_REGISTER, 5'd0, 29'h1FFFFFFF, 1'b1, 2'd0, 1'b1, KIND_CYCLIC, 16'd1, 4'd0},
          1'b1, ACK},
        '{'{OP_REGISTER, 5'd1, 29'd0, 1'b0, 2'd1, 1'b1, KIND_ON_START, 16'hFFFF, 4'd0},
          1'b1, ACK},
        '{'{OP_REGISTER, 5'd2, 29'h15555555, 1'b0, 2'd2, 1'b1, KIND_OTHER, 16'd1, 4'd0},
          1'b1, ACK},
        '{'{OP_REGISTER, 5'd3, 29'h0AAAAAAA, 1'b1, 2'd3, 1'b1, KIND_SPARE, 16'd2, 4'd0},
          1'b1, ACK},
        '{'{OP_REGISTER, 5'd4, 29'h123, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd1, 4'd0},
          1'b1, ACK},
        '{'{OP_REGISTER, 5'd5, 29'h7FF, 1'b0, 2'd3, 1'b1, KIND_CYCLIC, 16'd0, 4'd0},
          1'b1, ACK},
        '{'{OP_REGISTER, 5'd31, 29'h1FFFFFFF, 1'b1, 2'd3, 1'b1, KIND_SPARE, 16'hFFFF, 4'hF},
          1'b1, ACK},
        '{'{OP_REGISTER, 5'd6, 29'h1, 1'b0, 2'd0, 1'b1, KIND_CYCLIC, 16'd1, 4'd0},
          1'b1, ACK},
        '{'{OP_TICK, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'd0}, 1'b1, ACK},
        '{'{OP_START, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'd0}, 1'b1, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'h0}, 1'b0, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'h0}, 1'b0, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'hF}, 1'b0, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'h0}, 1'b0, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'h0}, 1'b0, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'h0}, 1'b0, ACK},
        '{'{OP_TICK, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'd0}, 1'b1, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'h5}, 1'b0, ACK},
        '{'{OP_PASS, 5'd0, 29'd0, 1'b0, 2'd0, 1'b0, KIND_CYCLIC, 16'd0, 4'hA}, 1'b0, ACK}
    };

    can_message_tx_scheduler_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int used_entries();
        return (int'(cfg_count) > ENTRIES) ? ENTRIES : int'(cfg_count);
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTED) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void advance_scheduler(input sched_cmd_t c);
        int n;
        int i;
        int ch;
        bit taken;
        bit send;
        ch_report_t r;
        n = used_entries();
        step_count = 0;
        case (c.op)
            OP_REGISTER: begin
                if (int'(c.idx) < n) begin
                    tbl_id[c.idx]        = c.id;
                    tbl_attr[c.idx]      = '{ext: c.ext, ch: c.ch, en: c.en, kind: c.kind};
                    tbl_period[c.idx]    = c.interval;
                    tbl_countdown[c.idx] = c.interval;
                    tbl_pending[c.idx]   = 1'b0;
                    tbl_written[c.idx]   = 1'b1;
                end
            end
            OP_START: begin
                for (i = 0; i < n; i++) begin
                    if (tbl_attr[i].en && tbl_attr[i].kind == KIND_ON_START) begin
                        tbl_pending[i] = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                for (i = 0; i < n; i++) begin
                    if (tbl_attr[i].en && tbl_attr[i].kind == KIND_CYCLIC) begin
                        tbl_countdown[i] = tbl_countdown[i] - 1'b1;
                        if (tbl_countdown[i] == '0) begin
                            tbl_countdown[i] = tbl_period[i];
                            tbl_pending[i]   = 1'b1;
                        end
                    end
                end
            end
            default: begin
                for (ch = 0; ch < CHANNELS; ch++) begin
                    if (cfg_active[ch]) begin
                        send = 1'b0;
                        case (ch_phase[ch])
                            PH_IDLE: begin
                                taken = 1'b0;
                                for (i = 0; i < n; i++) begin
                                    if (!taken && int'(tbl_attr[i].ch) == ch && tbl_pending[i]) begin
                                        taken          = 1'b1;
                                        tbl_pending[i] = 1'b0;
                                        held_entry[ch] = ENT_W'(i);
                                        held_id[ch]    = tbl_id[i];
                                        held_ext[ch]   = tbl_attr[i].ext;
                                        ch_phase[ch]   = PH_SEND;
                                    end
                                end
                            end
                            PH_SEND: begin
                                send         = 1'b1;
                                ch_phase[ch] = PH_WAIT;
                            end
                            PH_WAIT: begin
                                if (!c.busy[ch]) ch_phase[ch] = PH_COMPLETE;
                            end
                            PH_COMPLETE: ch_phase[ch] = PH_DONE;
                            default: ch_phase[ch] = PH_IDLE;
                        endcase
                        r       = '0;
                        r.ch    = 2'(ch);
                        r.phase = ch_phase[ch];
                        if (send) begin
                            r.send  = 1'b1;
                            r.entry = held_entry[ch];
                            r.id    = held_id[ch];
                            r.ext   = held_ext[ch];
                        end
                        step_reports[step_count] = r;
                        step_count++;
                    end
                end
            end
        endcase
        if (step_count == 0) begin
            step_reports[0] = ACK;
            step_count      = 1;
        end else begin
            step_reports[step_count-1].last = 1'b1;
        end
    endfunction

    function automatic sched_cmd_t random_cmd(input int n);
        sched_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) c.op = OP_REGISTER;
        else if (pick < 35) c.op = OP_START;
        else if (pick < 60) c.op = OP_TICK;
        else c.op = OP_PASS;
        if (n > 0 && $urandom_range(0, 99) < 85) c.idx = ENT_W'($urandom_range(0, n - 1));
        else c.idx = ENT_W'($urandom_range(0, 31));
        c.id  = ID_W'($urandom);
        c.ext = 1'($urandom_range(0, 1));
        c.ch  = 2'($urandom_range(0, 3));
        c.en  = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 45) c.kind = KIND_CYCLIC;
        else if (pick < 85) c.kind = KIND_ON_START;
        else c.kind = 2'($urandom_range(2, 3));
        pick = $urandom_range(0, 99);
        if (pick < 70) c.interval = CD_W'($urandom_range(1, 4));
        else if (pick < 90) c.interval = CD_W'($urandom_range(5, 20));
        else if (pick < 95) c.interval = '0;
        else c.interval = CD_W'($urandom_range(0, 65535));
        c.busy = 4'($urandom_range(0, 15));
        return c;
    endfunction

    task automatic send_item(input sched_cmd_t c, input bit typed, input ch_report_t want);
        int k;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, c.busy, c.interval, c.kind, c.en, c.ch, c.ext, c.id, c.idx};
        s_axis_tuser  <= c.op;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_scheduler(c);
        if (typed) begin
            reports_due.push_back(want);
        end else begin
            for (k = 0; k < step_count; k++) reports_due.push_back(step_reports[k]);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            note_fault($sformatf("register at %0d reads %h, want %h", addr, prdata, value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned count, input int unsigned active);
        idle_input();
        wait_drained();
        apb_write(ADDR_MESSAGE_COUNT, count);
        apb_write(ADDR_ACTIVE_CHANNELS, active);
        cfg_count  = CNT_CFG_W'(count);
        cfg_active = ACT_CFG_W'(active);
    endtask

    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_span <= $urandom_range(16, 96);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge i_clk) begin : result_check
        ch_report_t got;
        ch_report_t want;
        string diff;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tlast, m_axis_tdata[40:0]};
            if (reports_due.size() == 0) begin
                note_fault($sformatf("transfer %0d arrived with nothing due: ch=%0d ph=%0d last=%0d",
                                     transfer_count, got.ch, got.phase, got.last));
            end else begin
                want = reports_due.pop_front();
                diff = "";
                if (got.ch !== want.ch) diff = {diff, " channel_index"};
                if (got.phase !== want.phase) diff = {diff, " channel_phase"};
                if (got.send !== want.send) diff = {diff, " send_now"};
                if (got.entry !== want.entry) diff = {diff, " sent_entry"};
                if (got.id !== want.id) diff = {diff, " sent_id"};
                if (got.ext !== want.ext) diff = {diff, " sent_extended"};
                if (got.last !== want.last) diff = {diff, " last"};
                if (diff != "") begin
                    note_fault($sformatf(
                        "transfer %0d%s: want ch=%0d ph=%0d snd=%0d ent=%0d id=%h ext=%0d last=%0d, got ch=%0d ph=%0d snd=%0d ent=%0d id=%h ext=%0d last=%0d",
                        transfer_count, diff, want.ch, want.phase, want.send, want.entry,
                        want.id, want.ext, want.last, got.ch, got.phase, got.send, got.entry,
                        got.id, got.ext, got.last));
                end
            end
            transfer_count++;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_count  [PHASES];
        int unsigned phase_active [PHASES];
        sched_cmd_t c;
        int r;
        int p;
        int e;
        int j;
        int n;
        phase_count   = '{32, 63, 1, 17, 0, 40};
        phase_active  = '{15, 5, 1, 10, 15, 6};
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_REGISTER;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (r == DIR_RESET_ROWS) set_config(6, 15);
            send_item(dir_tab[r].cmd, dir_tab[r].typed, dir_tab[r].want);
        end

        for (p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) begin
                phase_count[p]  = $urandom_range(0, 63);
                phase_active[p] = $urandom_range(0, 15);
            end
            set_config(phase_count[p], phase_active[p]);
            n = used_entries();
            // fill every entry in range before anything scans the table
            for (e = 0; e < n; e++) begin
                if (!tbl_written[e]) begin
                    c     = random_cmd(n);
                    c.op  = OP_REGISTER;
                    c.idx = ENT_W'(e);
                    send_item(c, 1'b0, ACK);
                end
            end
            for (j = 0; j < ITEMS_PER_PHASE; j++) begin
                if (p == 1 && j == ITEMS_PER_PHASE / 2) begin
                    idle_input();
                    wait_drained();
                end
                send_item(random_cmd(n), 1'b0, ACK);
            end
        end

        idle_input();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- can_message_tx_scheduler_core.f -----
hdl/cmtxs_pkg.sv
hdl/cmtxs_entry_ram.sv
hdl/cmtxs_entry_unit.sv
hdl/can_message_tx_scheduler_core.sv
tb/sv/tb_can_message_tx_scheduler_core.sv
